[sv/lpc_pkg.sv]
// Shared constants and types for the line position centroid block.
package lpc_pkg;

  localparam int CHANNELS        = 8;
  localparam int FULL_SCALE      = 1023;
  localparam int CENTRE_DIVISOR  = 2;
  localparam int MIN_LEVEL_RESET = 50;

  // Beat and register widths
  localparam int SAMPLE_W    = 10;
  localparam int S_TDATA_W   = 16;
  localparam int POS_W       = 13;
  localparam int M_TDATA_W   = 16;
  localparam int MIN_W       = 10;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 1'd1;

  // Derived widths
  localparam int FS_W    = $clog2(FULL_SCALE + 1);
  localparam int LVL_W   = (FS_W > SAMPLE_W) ? FS_W : SAMPLE_W;
  localparam int IDX_W   = $clog2(CHANNELS + 1);
  localparam int MUL_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACC_W   = LVL_W + MUL_BITS;
  localparam int WT_W    = LVL_W + FS_W + $clog2(CHANNELS * (CHANNELS - 1) / 2 + 1);
  localparam int LT_W    = $clog2(((1 << LVL_W) - 1) * CHANNELS + 1);
  localparam int CENTRE  = (CHANNELS - 1) * FULL_SCALE / CENTRE_DIVISOR;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

endpackage

[sv/lpc_mac.sv]
// Bit-serial weight accumulator: level times index times full scale.
module lpc_mac
  import lpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mac_ctl_t            ctl,
  input  logic [LVL_W-1:0]    level,
  input  logic [MUL_BITS-1:0] idx,
  output logic                done,
  output logic [WT_W-1:0]     weight_total,
  output logic [LT_W-1:0]     level_total
);

  localparam int CNT_W = $clog2(MUL_BITS + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [ACC_W-1:0]    acc;
  logic [MUL_BITS-1:0] mplier;
  logic [LVL_W-1:0]    lvl;
  logic [ACC_W-1:0]    addend;
  logic [WT_W-1:0]     prod;

  assign done   = busy && (cnt == CNT_W'(MUL_BITS));
  assign addend = mplier[MUL_BITS-1] ? ACC_W'(lvl) : '0;
  assign prod   = WT_W'(acc) * WT_W'(FULL_SCALE);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      busy         <= 1'b0;
      cnt          <= '0;
      weight_total <= '0;
      level_total  <= '0;
    end else if (ctl.start) begin
      busy        <= 1'b1;
      cnt         <= '0;
      acc         <= '0;
      mplier      <= idx;
      lvl         <= level;
      level_total <= level_total + LT_W'(level);
    end else if (busy) begin
      if (done) begin
        // fold the finished product into the weight sum
        weight_total <= weight_total + prod;
        busy         <= 1'b0;
      end else begin
        acc    <= {acc[ACC_W-2:0], 1'b0} + addend;
        mplier <= mplier << 1;
        cnt    <= cnt + CNT_W'(1);
      end
    end
  end

endmodule

[sv/lpc_div.sv]
// Restoring divider, one quotient bit per cycle.
module lpc_div
  import lpc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WT_W-1:0] dividend,
  input  logic [LT_W-1:0] divisor,
  output logic            done,
  output logic [WT_W-1:0] quotient
);

  localparam int CNT_W = $clog2(WT_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [LT_W-1:0]  rem;
  logic [LT_W:0]    shifted;
  logic [LT_W+1:0]  trial;

  assign shifted = {rem, quotient[WT_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[LT_W+1]) begin
          rem      <= trial[LT_W-1:0];
          quotient <= {quotient[WT_W-2:0], 1'b1};
        end else begin
          rem      <= shifted[LT_W-1:0];
          quotient <= {quotient[WT_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/line_position_centroid_top.sv]
// Top level of the line position centroid block: control, config and output beat.
//
//  port group  | dir | contents
//  ------------+-----+-----------------------------------------------------
//  s_t*        | in  | sample beat: tdata[9:0] sample, tlast = final sample
//  m_t*        | out | result beat: tdata[12:0] position, tuser line_found
//  cfg_*       | in  | register write: index 0 invert_mode, 1 min_level
//
// Steps: a sample that does not count toward the centroid is taken in idle; a
// counted one then runs the bit-serial index multiply in lpc_mac. A last sample
// adds a check, the serial division and its done flag (skipped when no sample
// passed) and the load of the output register. Reset clears the set, the
// registers (min_level to 50) and the output beat. A stalled output holds its
// beat; a new set may be taken meanwhile, and its result waits in the final
// state until the beat drains.
module line_position_centroid_top
  import lpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] sample, rest zero
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [12:0] position (signed), rest zero
  output logic                 m_tuser,   // [0] line_found
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]       state;
  logic [IDX_W-1:0] idx;
  logic             last_q;
  logic             found_q;
  logic [POS_W-1:0] pos_q;
  logic             invert_mode;
  logic [MIN_W-1:0] min_level;

  logic [SAMPLE_W-1:0] sample;
  logic [LVL_W-1:0]    level;
  logic                in_beat;
  logic                in_range;
  logic                counted;
  logic                out_free;
  mac_ctl_t            mac_ctl;
  logic                mac_done;
  logic [WT_W-1:0]     weight_total;
  logic [LT_W-1:0]     level_total;
  logic                div_start;
  logic                div_done;
  logic [WT_W-1:0]     quotient;
  logic [WT_W-1:0]     pos_full;

  assign sample   = s_tdata[SAMPLE_W-1:0];
  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign in_range = (idx < IDX_W'(CHANNELS));
  assign out_free = !m_tvalid || m_tready;

  // White-line mode: invert against full scale, saturating at zero
  always_comb begin
    if (invert_mode) begin
      if ((LVL_W + 1)'(sample) > (LVL_W + 1)'(FULL_SCALE)) begin
        level = '0;
      end else begin
        level = LVL_W'(FULL_SCALE) - LVL_W'(sample);
      end
    end else begin
      level = LVL_W'(sample);
    end
  end

  assign counted = in_range && (level > LVL_W'(min_level));

  assign mac_ctl.start = in_beat && counted;
  assign mac_ctl.clear = (state == ST_OUT) && out_free;
  assign div_start     = (state == ST_FIN) && (level_total != '0);
  assign pos_full      = quotient - WT_W'(CENTRE);

  lpc_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mac_ctl),
    .level        (level),
    .idx          (idx[MUL_BITS-1:0]),
    .done         (mac_done),
    .weight_total (weight_total),
    .level_total  (level_total)
  );

  lpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (weight_total),
    .divisor  (level_total),
    .done     (div_done),
    .quotient (quotient)
  );

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mode <= 1'b0;
      min_level   <= MIN_W'(MIN_LEVEL_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVERT:    invert_mode <= cfg_data[0];
        REG_MIN_LEVEL: min_level   <= cfg_data[MIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      last_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            // advance the channel index, holding it once the array is full
            if (in_range) begin
              idx <= idx + IDX_W'(1);
            end
            last_q <= s_tlast;
            if (counted) begin
              state <= ST_MAC;
            end else if (s_tlast) begin
              state <= ST_FIN;
            end
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            state <= last_q ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (level_total == '0) begin
            // no sample passed: report no line at offset zero
            found_q <= 1'b0;
            pos_q   <= '0;
            state   <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            found_q <= 1'b1;
            pos_q   <= pos_full[POS_W-1:0];
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            idx   <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: load when no beat is held or the held one is taken, drop on take-up
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= M_TDATA_W'(pos_q);
      m_tuser  <= found_q;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

[sv/lpc_chk.sv]
// Port-level checks for the line position centroid block, bound to the top level.
module lpc_chk
  import lpc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_no_line_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("no line found but position not zero");

  a_mid_set_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("result beat raised straight after a mid-set sample");

endmodule

bind line_position_centroid_top lpc_chk u_lpc_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
